@@ hw/rtl/waveform_min_max_decimator_core_macros.svh @@
// Assertion helpers for the checker file of the decimator.
`ifndef WAVEFORM_MIN_MAX_DECIMATOR_CORE_MACROS_SVH
`define WAVEFORM_MIN_MAX_DECIMATOR_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define WMMD_ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("decimator assertion failed");

// Concurrent assertion on the block clock and reset.
`define WMMD_ASSERT(lbl, prop) \
  `WMMD_ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

@@ hw/rtl/wmmd_pkg.sv @@
package wmmd_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COLUMN_BITS    = 16;
  localparam int PMAX_BITS      = SAMPLE_BITS - 1;
  localparam int FRAME_BITS     = 48;
  localparam int ACC_BITS       = 48;
  localparam int FRAC_BITS      = 16;
  localparam int SPP_BITS       = 32;
  localparam int OFFSET_BITS    = 40;
  localparam int CFG_DATA_BITS  = 40;
  localparam int CFG_INDEX_BITS = 2;

  localparam int IN_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = COLUMN_BITS + SAMPLE_BITS + PMAX_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [SPP_BITS-1:0]   SPP_ONE   = 32'h0001_0000;
  localparam logic [SPP_BITS-1:0]   SPP_RESET = 32'h0400_0000;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SPP    = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_index_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_FLUSH  = 1'b1
  } command_e;

  typedef struct packed {
    command_e                      command;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0]        column_index;
    logic signed [SAMPLE_BITS-1:0] peak_min;
    logic [PMAX_BITS-1:0]          peak_max;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t result;
  } col_out_t;

endpackage

@@ hw/rtl/wmmd_in_reg.sv @@
module wmmd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  wmmd_pkg::item_t item_i,
  input  logic            take_i,
  output logic            valid_o,
  output wmmd_pkg::item_t item_o
);
  import wmmd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/wmmd_column_unit.sv @@
module wmmd_column_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wmmd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [wmmd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                take_i,
  input  wmmd_pkg::item_t                     item_i,
  output wmmd_pkg::col_out_t                  col_o
);
  import wmmd_pkg::*;

  logic [SPP_BITS-1:0]           step_q, step_d;
  logic [OFFSET_BITS-1:0]        offset_q, offset_d;
  logic [COLUMN_BITS-1:0]        count_q, count_d;
  logic [FRAME_BITS-1:0]         frame_q, frame_d;
  logic [FRAME_BITS-1:0]         rel_q, rel_d;
  logic [COLUMN_BITS-1:0]        column_q, column_d;
  logic [ACC_BITS-1:0]           acc_q, acc_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic                          has_q, has_d;

  logic                          past, in_range, hit, upd, cfg_known;
  logic [COLUMN_BITS-1:0]        column_inc;
  logic [SPP_BITS-1:0]           cfg_step;
  logic signed [SAMPLE_BITS-1:0] base_min, base_max;

  // rel_q tracks frame_q - offset_q once the offset is reached, so the
  // boundary test needs no subtraction in this path.
  assign past       = frame_q >= FRAME_BITS'(offset_q);
  assign in_range   = column_q < count_q;
  assign hit        = rel_q >= FRAME_BITS'(acc_q[ACC_BITS-1:FRAC_BITS]);
  assign column_inc = column_q + COLUMN_BITS'(1);
  assign cfg_step   = (cfg_data_i[SPP_BITS-1:0] < SPP_ONE) ? SPP_ONE
                                                           : cfg_data_i[SPP_BITS-1:0];

  always_comb begin
    step_d    = step_q;
    offset_d  = offset_q;
    count_d   = count_q;
    frame_d   = frame_q;
    rel_d     = rel_q;
    column_d  = column_q;
    acc_d     = acc_q;
    min_d     = min_q;
    max_d     = max_q;
    has_d     = has_q;
    upd       = 1'b0;
    cfg_known = 1'b0;
    base_min  = min_q;
    base_max  = max_q;

    col_o.emit                = 1'b0;
    col_o.result.column_index = column_q;
    col_o.result.peak_min     = min_q;
    col_o.result.peak_max     = max_q[PMAX_BITS-1:0];

    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SPP: begin
          step_d    = cfg_step;
          cfg_known = 1'b1;
        end
        CFG_OFFSET: begin
          offset_d  = cfg_data_i[OFFSET_BITS-1:0];
          cfg_known = 1'b1;
        end
        CFG_COUNT: begin
          count_d   = cfg_data_i[COLUMN_BITS-1:0];
          cfg_known = 1'b1;
        end
        default: begin
          cfg_known = 1'b0;
        end
      endcase
      // A write to any of the three known register indices rearms and drops the open column.
      if (cfg_known) begin
        frame_d  = '0;
        rel_d    = '0;
        column_d = '0;
        acc_d    = ACC_BITS'(step_d);
        min_d    = '0;
        max_d    = '0;
        has_d    = 1'b0;
      end
    end else if (take_i) begin
      if (item_i.command == CMD_FLUSH) begin
        col_o.emit = has_q && in_range;
        frame_d    = '0;
        rel_d      = '0;
        column_d   = '0;
        acc_d      = ACC_BITS'(step_q);
        min_d      = '0;
        max_d      = '0;
        has_d      = 1'b0;
      end else begin
        if (frame_q != FRAME_MAX) begin
          frame_d = frame_q + FRAME_BITS'(1);
          rel_d   = past ? rel_q + FRAME_BITS'(1) : '0;
        end
        if (in_range && past) begin
          upd = 1'b1;
          if (hit) begin
            col_o.emit = has_q;
            column_d   = column_inc;
            acc_d      = acc_q + ACC_BITS'(step_q);
            base_min   = '0;
            base_max   = '0;
            min_d      = '0;
            max_d      = '0;
            has_d      = 1'b0;
            upd        = column_inc < count_q;
          end
          if (upd) begin
            min_d = (item_i.sample < base_min) ? item_i.sample : base_min;
            max_d = (item_i.sample > base_max) ? item_i.sample : base_max;
            has_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= SPP_RESET;
      offset_q <= '0;
      count_q  <= '0;
      frame_q  <= '0;
      rel_q    <= '0;
      column_q <= '0;
      acc_q    <= ACC_BITS'(SPP_RESET);
      min_q    <= '0;
      max_q    <= '0;
      has_q    <= 1'b0;
    end else begin
      step_q   <= step_d;
      offset_q <= offset_d;
      count_q  <= count_d;
      frame_q  <= frame_d;
      rel_q    <= rel_d;
      column_q <= column_d;
      acc_q    <= acc_d;
      min_q    <= min_d;
      max_q    <= max_d;
      has_q    <= has_d;
    end
  end

endmodule

@@ hw/rtl/wmmd_out_reg.sv @@
module wmmd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  wmmd_pkg::col_out_t col_i,
  input  logic               m_ready_i,
  output logic               m_valid_o,
  output logic               free_o,
  output wmmd_pkg::result_t  result_o
);
  import wmmd_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;
  logic    load;

  assign free_o = !valid_q || m_ready_i;
  assign load   = take_i && col_i.emit;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= col_i.result;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = result_q;

endmodule

@@ hw/rtl/waveform_min_max_decimator_core.sv @@
// Each accepted request is held in the input register; the result register loads from it once
// it is free, and the master side takes the result from the result register.
// Throughput: one request per cycle; each one passes the input register, then the column
// compare, accumulate and min/max update, which loads any result into the result register.
// A result stalled on the master side holds the next request in the input register.
// Reset: rst_ni is asynchronous and active low; it empties both registers and sets 1024.0
module waveform_min_max_decimator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample
  input  logic [wmmd_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // column_index, peak_min, peak_max, zero padding
  output logic [wmmd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [wmmd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [wmmd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  // samples per column, offset zero and zero columns, with the column tracking rearmed.
  import wmmd_pkg::*;

  item_t    in_item, held_item;
  logic     held_valid, out_free, take;
  col_out_t col;
  result_t  result;

  assign in_item.command = command_e'(s_axis_tuser);
  assign in_item.sample  = s_axis_tdata[SAMPLE_BITS-1:0];

  // The held request is processed whenever the result register can take a result.
  assign take = held_valid && out_free;

  wmmd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .item_i    (in_item),
    .take_i    (take),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  wmmd_column_unit u_column_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .item_i      (held_item),
    .col_o       (col)
  );

  wmmd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .col_i     (col),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .free_o    (out_free),
    .result_o  (result)
  );

  assign m_axis_tdata = OUT_DATA_BITS'({result.peak_max, result.peak_min,
                                        result.column_index});

endmodule

@@ hw/rtl/wmmd_checker.sv @@
`include "waveform_min_max_decimator_core_macros.svh"

module wmmd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [wmmd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
  import wmmd_pkg::*;

  logic                   min_sign, min_zero, s_accept;
  logic [SAMPLE_BITS-1:0] min_field;

  assign min_field = m_axis_tdata[COLUMN_BITS+SAMPLE_BITS-1:COLUMN_BITS];
  assign min_sign  = min_field[SAMPLE_BITS-1];
  assign min_zero  = min_field == '0;
  assign s_accept  = s_axis_tvalid && s_axis_tready;

  // A stalled result keeps its contents.
  `WMMD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // The running minimum starts at zero, so a reported minimum is never positive.
  `WMMD_ASSERT(a_min_nonpositive, m_axis_tvalid |-> (min_sign || min_zero))

  // A downstream that takes results never stalls the upstream side.
  `WMMD_ASSERT(a_ready_follows, m_axis_tready |-> s_axis_tready)

  // A new result only follows an accepted request that has passed the input register.
  `WMMD_ASSERT(a_result_has_cause, $rose(m_axis_tvalid) |-> $past(s_accept, 2))

endmodule

bind waveform_min_max_decimator_core wmmd_checker u_wmmd_checker (.*);

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wmmd_pkg::*;

  localparam int PIPE_CYCLES = 4;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SPP_BITS-1:0] SPP_TOP = 32'hFFFF_0000;
  localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  // sample
  logic [IN_DATA_BITS-1:0]   s_axis_tdata;
  // command
  logic                      s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // column_index, peak_min, peak_max, zero padding
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
  logic                      cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;

  // Predicted configuration and column tracking.
  logic [SPP_BITS-1:0]           cfg_spp;
  logic [OFFSET_BITS-1:0]        cfg_offset;
  logic [COLUMN_BITS-1:0]        cfg_columns;
  logic [FRAME_BITS-1:0]         frame_cnt;
  logic [COLUMN_BITS-1:0]        open_col;
  logic [ACC_BITS-1:0]           col_end_acc;
  logic signed [SAMPLE_BITS-1:0] col_min;
  logic signed [SAMPLE_BITS-1:0] col_max;
  logic                          col_filled;
  result_t                       pending_peaks[$];

  result_t                       want_peak;
  logic [COLUMN_BITS-1:0]        got_col;
  logic signed [SAMPLE_BITS-1:0] got_min;
  logic [PMAX_BITS-1:0]          got_max;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int err_cnt = 0;
  int items_sent = 0;
  int peaks_seen = 0;
  int quiet_cycles = 0;

  waveform_min_max_decimator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // A step below one frame per column behaves as exactly one.
  function automatic logic [ACC_BITS-1:0] column_step();
    return (cfg_spp < SPP_ONE) ? ACC_BITS'(SPP_ONE) : ACC_BITS'(cfg_spp);
  endfunction

  function automatic void rearm_columns();
    frame_cnt   = '0;
    open_col    = '0;
    col_end_acc = column_step();
    col_min     = '0;
    col_max     = '0;
    col_filled  = 1'b0;
  endfunction

  function automatic void report_open_column();
    result_t r;
    r.column_index = open_col;
    r.peak_min     = col_min;
    r.peak_max     = col_max[PMAX_BITS-1:0];
    pending_peaks.push_back(r);
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_SPP:    cfg_spp = data[SPP_BITS-1:0];
      CFG_OFFSET: cfg_offset = data[OFFSET_BITS-1:0];
      CFG_COUNT:  cfg_columns = data[COLUMN_BITS-1:0];
      default:    return;
    endcase
    rearm_columns();
  endfunction

  function automatic void track_item(input item_t it);
    logic [FRAME_BITS-1:0]         frame;
    logic [FRAME_BITS-1:0]         rel;
    logic signed [SAMPLE_BITS-1:0] s;
    s = it.sample;
    if (it.command == CMD_FLUSH) begin
      if (col_filled && open_col < cfg_columns) report_open_column();
      rearm_columns();
      return;
    end
    frame = frame_cnt;
    if (frame_cnt != FRAME_MAX) frame_cnt = frame_cnt + FRAME_BITS'(1);
    if (open_col >= cfg_columns || frame < FRAME_BITS'(cfg_offset)) return;
    rel = frame - FRAME_BITS'(cfg_offset);
    // The first frame at or past the column end closes the open column.
    if (rel >= (col_end_acc >> FRAC_BITS)) begin
      if (col_filled) report_open_column();
      open_col    = open_col + COLUMN_BITS'(1);
      col_end_acc = col_end_acc + column_step();
      col_min     = '0;
      col_max     = '0;
      col_filled  = 1'b0;
      if (open_col >= cfg_columns) return;
    end
    if (s < col_min) col_min = s;
    if (s > col_max) col_max = s;
    col_filled = 1'b1;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int pick;
    int near_zero;
    pick = $urandom_range(0, 99);
    near_zero = int'($urandom_range(0, 512)) - 256;
    if (pick < 4) return SMP_MAX;
    if (pick < 8) return SMP_MIN;
    if (pick < 11) return '0;
    if (pick < 40) return near_zero[SAMPLE_BITS-1:0];
    return SAMPLE_BITS'($urandom);
  endfunction

  // Called and returns at a falling edge; tvalid stays high for a following request.
  task automatic send_item(input command_e cmd, input logic signed [SAMPLE_BITS-1:0] smp);
    item_t it;
    it.command = cmd;
    it.sample  = smp;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'(smp);
    s_axis_tuser  <= cmd;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    track_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Registers change only with the pipeline empty.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_peaks.size() != 0) @(negedge clk_i);
    repeat (PIPE_CYCLES) @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_one(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    write_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup_clip(input logic [CFG_DATA_BITS-1:0] spp,
                            input logic [CFG_DATA_BITS-1:0] off,
                            input logic [CFG_DATA_BITS-1:0] cols,
                            input bit with_unused);
    wait_idle();
    write_reg(CFG_SPP, spp);
    write_reg(CFG_OFFSET, off);
    if (with_unused) write_reg(CFG_UNUSED, rand40());
    write_reg(CFG_COUNT, cols);
    cfg_we_i <= 1'b0;
  endtask

  // Reset values give zero columns, so nothing may come out.
  task automatic test_zero_columns();
    send_item(CMD_SAMPLE, SMP_MAX);
    send_item(CMD_SAMPLE, SMP_MIN);
    send_item(CMD_SAMPLE, '0);
    send_item(CMD_FLUSH, rand_sample());
  endtask

  // Step below one: every frame is its own column; frames past the last one are ignored.
  task automatic test_peak_extremes();
    setup_clip(CFG_DATA_BITS'(32'h0000_8000), '0, CFG_DATA_BITS'(4), 1'b0);
    send_item(CMD_SAMPLE, SMP_MAX);
    send_item(CMD_SAMPLE, SMP_MIN);
    send_item(CMD_SAMPLE, SAMPLE_BITS'(5));
    send_item(CMD_SAMPLE, SAMPLE_BITS'(-3));
    send_item(CMD_SAMPLE, SAMPLE_BITS'(100));
    send_item(CMD_SAMPLE, SAMPLE_BITS'(7));
    send_item(CMD_FLUSH, '0);
  endtask

  // 1.5 frames per column after two skipped frames; the flush closes column one.
  task automatic test_fraction_offset();
    setup_clip(CFG_DATA_BITS'(32'h0001_8000), CFG_DATA_BITS'(2), CFG_DATA_BITS'(2), 1'b0);
    send_item(CMD_SAMPLE, SAMPLE_BITS'(-1));
    send_item(CMD_SAMPLE, SAMPLE_BITS'(1));
    send_item(CMD_SAMPLE, SAMPLE_BITS'(10));
    send_item(CMD_SAMPLE, SAMPLE_BITS'(-20));
    send_item(CMD_SAMPLE, SAMPLE_BITS'(30));
    send_item(CMD_FLUSH, '0);
  endtask

  // A register write drops the open column; a write to an unused index leaves it alone.
  task automatic test_write_rearm();
    setup_clip(CFG_DATA_BITS'(SPP_TOP), '0, CFG_DATA_BITS'(16'hFFFF), 1'b0);
    repeat (3) send_item(CMD_SAMPLE, rand_sample());
    write_one(CFG_OFFSET, '0);
    send_item(CMD_SAMPLE, SMP_MIN);
    write_one(CFG_UNUSED, rand40());
    send_item(CMD_SAMPLE, SMP_MAX);
    send_item(CMD_FLUSH, '0);
  endtask

  task automatic test_random_clips(input int src_pct, input int snk_pct, input int budget);
    int stop_at;
    int pick;
    int clip_len;
    logic [CFG_DATA_BITS-1:0] spp;
    logic [CFG_DATA_BITS-1:0] off;
    logic [CFG_DATA_BITS-1:0] cols;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      // Bits above each register width are junk the block must drop.
      spp  = rand40();
      off  = rand40();
      cols = rand40();
      pick = $urandom_range(0, 99);
      if (pick < 8) spp[SPP_BITS-1:0] = $urandom_range(0, 32'h0000_FFFF);
      else if (pick < 12) spp[SPP_BITS-1:0] = SPP_TOP;
      else if (pick < 24) spp[SPP_BITS-1:0] = SPP_ONE;
      else if (pick >= 28) spp[SPP_BITS-1:0] = $urandom_range(32'h0001_0000, 32'h0006_0000);
      pick = $urandom_range(0, 99);
      if (pick < 60) off = CFG_DATA_BITS'($urandom_range(0, 12));
      else if (pick < 75) off = '0;
      else if (pick < 85) off = CFG_DATA_BITS'(OFFSET_TOP);
      else if (pick < 92) off = CFG_DATA_BITS'($urandom_range(0, 200));
      pick = $urandom_range(0, 99);
      if (pick < 6) cols[COLUMN_BITS-1:0] = '0;
      else if (pick < 12) cols[COLUMN_BITS-1:0] = '1;
      else if (pick < 20) cols[COLUMN_BITS-1:0] = COLUMN_BITS'(1);
      else cols[COLUMN_BITS-1:0] = COLUMN_BITS'($urandom_range(1, 40));
      setup_clip(spp, off, cols, $urandom_range(0, 9) == 0);
      clip_len = $urandom_range(5, 80);
      repeat (clip_len) begin
        if ($urandom_range(0, 99) < 4) send_item(CMD_FLUSH, rand_sample());
        else send_item(CMD_SAMPLE, rand_sample());
      end
      if ($urandom_range(0, 99) < 85) send_item(CMD_FLUSH, rand_sample());
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_col = m_axis_tdata[COLUMN_BITS-1:0];
      got_min = m_axis_tdata[COLUMN_BITS +: SAMPLE_BITS];
      got_max = m_axis_tdata[COLUMN_BITS+SAMPLE_BITS +: PMAX_BITS];
      peaks_seen++;
      if (pending_peaks.size() == 0) begin
        $error("unexpected column result: column_index %0d", got_col);
        err_cnt++;
      end else begin
        want_peak = pending_peaks.pop_front();
        if (got_col !== want_peak.column_index) begin
          $error("column_index: expected %0d, got %0d", want_peak.column_index, got_col);
          err_cnt++;
        end
        if (got_min !== want_peak.peak_min) begin
          $error("peak_min: expected %0d, got %0d", want_peak.peak_min, got_min);
          err_cnt++;
        end
        if (got_max !== want_peak.peak_max) begin
          $error("peak_max: expected %0d, got %0d", want_peak.peak_max, got_max);
          err_cnt++;
        end
      end
    end
  end

  // Ends a run that stops moving requests on both sides.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SAMPLE;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_SPP;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    cfg_spp       = SPP_RESET;
    cfg_offset    = '0;
    cfg_columns   = '0;
    rearm_columns();
    src_idle_pct  = 20;
    snk_stall_pct = 65;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_zero_columns();
    test_peak_extremes();
    test_fraction_offset();
    test_write_rearm();
    test_random_clips(20, 65, 500);
    test_random_clips(65, 20, 500);
    test_random_clips(0, 0, 500);
    wait_idle();

    $display("Sent %0d requests: zero columns, peak extremes, fractional steps, offsets,",
             items_sent);
    $display("register rearm and random clips; %0d column peaks checked, %0d mismatches.",
             peaks_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/wmmd_pkg.sv
hw/rtl/wmmd_in_reg.sv
hw/rtl/wmmd_column_unit.sv
hw/rtl/wmmd_out_reg.sv
hw/rtl/waveform_min_max_decimator_core.sv
hw/rtl/wmmd_checker.sv
sim/tb_top.sv
